// ===== design/jvm_alu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jvm_alu_pkg
// Shared operation codes and pipeline stage records of the integer ALU.
// ---------------------------------------------------------------------------
package jvm_alu_pkg;

   localparam int DataWidth = 64;
   localparam int HalfWidth = 32;
   localparam int KindWidth = 4;
   localparam int DivSteps  = DataWidth;

   localparam logic [5:0] ShiftMaskInt  = 6'h1f;
   localparam logic [5:0] ShiftMaskLong = 6'h3f;

   typedef enum logic [KindWidth-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_REM  = 4'd4,
      OP_NEG  = 4'd5,
      OP_SHL  = 4'd6,
      OP_SHR  = 4'd7,
      OP_USHR = 4'd8,
      OP_AND  = 4'd9,
      OP_OR   = 4'd10,
      OP_XOR  = 4'd11
   } op_type;

   // Operands after decode.
   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 wide;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic [5:0]           shamt;
   } dec_type;

   // Simple results, partial products and divider set-up.
   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 wide;
      logic                 dz;
      logic                 nq;
      logic                 nr;
      logic [DataWidth-1:0] res;
      logic [DataWidth-1:0] p0;
      logic [HalfWidth-1:0] p1;
      logic [HalfWidth-1:0] p2;
      logic [DataWidth-1:0] ua;
      logic [DataWidth-1:0] ub;
   } ex_type;

   // One step of the restoring divider.
   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 wide;
      logic                 dz;
      logic                 nq;
      logic                 nr;
      logic [DataWidth-1:0] res;
      logic [DataWidth-1:0] r;
      logic [DataWidth-1:0] q;
      logic [DataWidth-1:0] ub;
   } div_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 wide;
      logic [DataWidth-1:0] result;
      logic                 status;
   } out_type;

endpackage
`default_nettype wire

// ===== design/jvm_integer_alu_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jvm_integer_alu_unit
// Pipelined Java int/long integer ALU with a one-bit-per-stage divider.
// ---------------------------------------------------------------------------
// Channel  | Ports                     | Content
// request  | req_tvalid/tready/tdata/  | tdata: operand_a, operand_b
//          | tuser                     | tuser: kind, wide
// response | rsp_tvalid/tready/tdata/  | tdata: result
//          | tuser                     | tuser: status
//
// One operation is accepted every cycle while the response side does not stall.
// Every operation passes through the 64 stages of the divider, which all
// operations pass through so that results stay in order.
// Reset clears the valid bits only. A stall on the response side holds the
// whole pipeline; the request side is ready whenever the output is free.
// ---------------------------------------------------------------------------
module jvm_integer_alu_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,   // operand_a [63:0], operand_b [127:64]
   input  wire  [4:0]   req_tuser,   // kind [3:0], wide [4]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,   // result [63:0]
   output logic [0:0]   rsp_tuser    // status [0]
);

   localparam int W = jvm_alu_pkg::DataWidth;
   localparam int H = jvm_alu_pkg::HalfWidth;
   localparam int N = jvm_alu_pkg::DivSteps;

   logic adv;

   jvm_alu_pkg::dec_type dec_ff, dec_in;
   logic                 dec_v_ff;
   jvm_alu_pkg::ex_type  ex_ff, ex_in;
   logic                 ex_v_ff;
   jvm_alu_pkg::div_type dv_ff [0:N];
   jvm_alu_pkg::div_type dv_in [0:N];
   logic [N:0]           dv_v_ff;
   jvm_alu_pkg::out_type out_ff, out_in;
   logic                 out_v_ff;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.result;
   assign rsp_tuser  = out_ff.status;

   // Decode: in int mode both operands are sign-extended from 32 bits.
   always_comb begin
      logic [W-1:0] a;
      logic [W-1:0] b;
      a = req_tdata[W-1:0];
      b = req_tdata[2*W-1:W];
      dec_in.kind = req_tuser[3:0];
      dec_in.wide = req_tuser[4];
      if (!req_tuser[4]) begin
         a = {{H{a[H-1]}}, a[H-1:0]};
         b = {{H{b[H-1]}}, b[H-1:0]};
         dec_in.shamt = b[5:0] & jvm_alu_pkg::ShiftMaskInt;
      end else begin
         dec_in.shamt = b[5:0] & jvm_alu_pkg::ShiftMaskLong;
      end
      dec_in.a = a;
      dec_in.b = b;
   end

   // Execute: simple operations, partial products, divider set-up.
   always_comb begin
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] r;
      a = dec_ff.a;
      b = dec_ff.b;
      r = '0;
      case (dec_ff.kind)
         jvm_alu_pkg::OP_ADD:  r = a + b;
         jvm_alu_pkg::OP_SUB:  r = a - b;
         jvm_alu_pkg::OP_NEG:  r = '0 - a;
         jvm_alu_pkg::OP_SHL:  r = a << dec_ff.shamt;
         jvm_alu_pkg::OP_SHR:  r = $signed(a) >>> dec_ff.shamt;
         jvm_alu_pkg::OP_USHR: begin
            if (dec_ff.wide) r = a >> dec_ff.shamt;
            else r = {{H{1'b0}}, a[H-1:0]} >> dec_ff.shamt;
         end
         jvm_alu_pkg::OP_AND:  r = a & b;
         jvm_alu_pkg::OP_OR:   r = a | b;
         jvm_alu_pkg::OP_XOR:  r = a ^ b;
         default:              r = '0;
      endcase
      ex_in.kind = dec_ff.kind;
      ex_in.wide = dec_ff.wide;
      ex_in.res  = r;
      ex_in.dz   = (b == '0);
      ex_in.nq   = a[W-1] ^ b[W-1];
      ex_in.nr   = a[W-1];
      ex_in.ua   = a[W-1] ? ('0 - a) : a;
      ex_in.ub   = b[W-1] ? ('0 - b) : b;
      ex_in.p0   = W'(a[H-1:0]) * W'(b[H-1:0]);
      ex_in.p1   = H'(a[H-1:0] * b[W-1:H]);
      ex_in.p2   = H'(a[W-1:H] * b[H-1:0]);
   end

   // Divider entry; the low product word of a multiply is summed here.
   always_comb begin
      dv_in[0].kind = ex_ff.kind;
      dv_in[0].wide = ex_ff.wide;
      dv_in[0].dz   = ex_ff.dz;
      dv_in[0].nq   = ex_ff.nq;
      dv_in[0].nr   = ex_ff.nr;
      dv_in[0].r    = '0;
      dv_in[0].q    = ex_ff.ua;
      dv_in[0].ub   = ex_ff.ub;
      if (ex_ff.kind == jvm_alu_pkg::OP_MUL) begin
         dv_in[0].res = ex_ff.p0 + {ex_ff.p1 + ex_ff.p2, {H{1'b0}}};
      end else begin
         dv_in[0].res = ex_ff.res;
      end
   end

   // Each stage shifts one dividend bit into the partial remainder.
   for (genvar k = 1; k <= N; k++) begin : g_div
      always_comb begin
         logic [W:0] rs;
         logic [W:0] diff;
         rs   = {dv_ff[k-1].r, dv_ff[k-1].q[W-1]};
         diff = rs - {1'b0, dv_ff[k-1].ub};
         dv_in[k] = dv_ff[k-1];
         if (!diff[W]) begin
            dv_in[k].r = diff[W-1:0];
            dv_in[k].q = {dv_ff[k-1].q[W-2:0], 1'b1};
         end else begin
            dv_in[k].r = rs[W-1:0];
            dv_in[k].q = {dv_ff[k-1].q[W-2:0], 1'b0};
         end
      end
   end

   // Sign correction, divide-by-zero and int-mode sign extension.
   always_comb begin
      logic [W-1:0] r;
      logic         st;
      st = 1'b0;
      case (dv_ff[N].kind)
         jvm_alu_pkg::OP_DIV: begin
            st = dv_ff[N].dz;
            if (dv_ff[N].dz) r = '0;
            else r = dv_ff[N].nq ? ('0 - dv_ff[N].q) : dv_ff[N].q;
         end
         jvm_alu_pkg::OP_REM: begin
            st = dv_ff[N].dz;
            if (dv_ff[N].dz) r = '0;
            else r = dv_ff[N].nr ? ('0 - dv_ff[N].r) : dv_ff[N].r;
         end
         default: r = dv_ff[N].res;
      endcase
      if (!dv_ff[N].wide) r = {{H{r[H-1]}}, r[H-1:0]};
      out_in.kind   = dv_ff[N].kind;
      out_in.wide   = dv_ff[N].wide;
      out_in.result = r;
      out_in.status = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_v_ff <= 1'b0;
         ex_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         dec_v_ff <= req_tvalid;
         ex_v_ff  <= dec_v_ff;
         dv_v_ff  <= {dv_v_ff[N-1:0], ex_v_ff};
         out_v_ff <= dv_v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dec_ff <= dec_in;
         ex_ff  <= ex_in;
         for (int k = 0; k <= N; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_ff <= out_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("divide-by-zero status with non-zero result");

   a_dz_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (out_ff.kind == jvm_alu_pkg::OP_DIV || out_ff.kind == jvm_alu_pkg::OP_REM))
      else $error("error status on an operation that cannot divide");

   a_int_sext: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.wide |-> rsp_tdata[W-1:H] == {H{rsp_tdata[H-1]}})
      else $error("int result not sign-extended");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer ALU regression
// Drives Java int and long operations through the request stream, predicts
// every response and compares it field by field in order of transfer.
// ---------------------------------------------------------------------------
module testbench;

   localparam int Latency    = 68;
   localparam int RandomOps  = 450;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [3:0]  kind;
      logic        wide;
      logic [63:0] a;
      logic [63:0] b;
      logic        known;
      logic [63:0] res;
      logic        st;
   } op_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [4:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   logic [64:0] pending_results[$];
   int          failures = 0;
   int          cycles = 0;
   int          sent = 0;
   int          checked = 0;
   int          send_idle = 0;
   int          recv_idle = 0;

   jvm_integer_alu_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] sx32(input logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   // Returns {status, result} for one operation.
   function automatic logic [64:0] alu_outcome(input logic [3:0] kind, input logic wide,
                                               input logic [63:0] a_in,
                                               input logic [63:0] b_in);
      logic [63:0] a, b, r, ma, mb, q;
      logic [5:0]  sh;
      logic        st;
      a  = wide ? a_in : sx32(a_in);
      b  = wide ? b_in : sx32(b_in);
      sh = wide ? b[5:0] : {1'b0, b[4:0]};
      r  = '0;
      st = 1'b0;
      case (kind) inside
         jvm_alu_pkg::OP_ADD: r = a + b;
         jvm_alu_pkg::OP_SUB: r = a - b;
         jvm_alu_pkg::OP_MUL: r = a * b;
         jvm_alu_pkg::OP_DIV, jvm_alu_pkg::OP_REM: begin
            if (b == 0) begin
               st = 1'b1;
            end else begin
               ma = a[63] ? -a : a;
               mb = b[63] ? -b : b;
               if (kind == jvm_alu_pkg::OP_DIV) begin
                  q = ma / mb;
                  r = (a[63] ^ b[63]) ? -q : q;
               end else begin
                  q = ma % mb;
                  r = a[63] ? -q : q;
               end
            end
         end
         jvm_alu_pkg::OP_NEG:  r = -a;
         jvm_alu_pkg::OP_SHL:  r = a << sh;
         jvm_alu_pkg::OP_SHR:  r = $signed(a) >>> sh;
         jvm_alu_pkg::OP_USHR: r = wide ? a >> sh : {32'h0, a[31:0]} >> sh;
         jvm_alu_pkg::OP_AND:  r = a & b;
         jvm_alu_pkg::OP_OR:   r = a | b;
         jvm_alu_pkg::OP_XOR:  r = a ^ b;
         default: r = '0;
      endcase
      if (!wide) r = sx32(r);
      return {st, r};
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = {1'b1, 63'h0};
         1: v = {1'b0, {63{1'b1}}};
         2: v = 64'hffffffff_ffffffff;
         3: v = 64'(signed'(32'($urandom_range(0, 70)) - 35));
         4: v = {$urandom, 32'h8000_0000};
         default: ;
      endcase
      return v;
   endfunction

   // Leaves the request valid after a transfer so that items can follow back
   // to back; the caller drops it when the stream pauses.
   task automatic send_op(input op_row_type row);
      logic [64:0] exp_out;
      exp_out = row.known ? {row.st, row.res}
                          : alu_outcome(row.kind, row.wide, row.a, row.b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {row.b, row.a};
      req_tuser  <= {row.wide, row.kind};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(exp_out);
      sent++;
      @(negedge clock);
   endtask

   // Receiver: ready toggles at the falling edge, transfers checked at the rising edge.
   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response result=%h status=%b", $time, rsp_tdata,
                     rsp_tuser);
            failures++;
         end else begin
            logic [64:0] e;
            e = pending_results.pop_front();
            if (rsp_tdata !== e[63:0] || rsp_tuser[0] !== e[64]) begin
               $display("%0t: mismatch expected result=%h status=%b, actual result=%h status=%b",
                        $time, e[63:0], e[64], rsp_tdata, rsp_tuser);
               failures++;
            end
            checked++;
         end
      end
   end

   initial begin
      wait (cycles >= CycleLimit);
      $display("timeout after %0d cycles", cycles);
      $display("jvm_integer_alu_unit regression: fail");
      $finish;
   end

   localparam logic [63:0] MinL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MaxL = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MinI = 64'hffff_ffff_8000_0000;
   localparam logic [63:0] M1   = 64'hffff_ffff_ffff_ffff;

   op_row_type directed[] = '{
      '{jvm_alu_pkg::OP_ADD,  1, MaxL, 64'd1, 1, MinL, 0},
      '{jvm_alu_pkg::OP_ADD,  0, 64'h7fff_ffff, 64'd1, 1, MinI, 0},
      '{jvm_alu_pkg::OP_SUB,  1, MinL, 64'd1, 1, MaxL, 0},
      '{jvm_alu_pkg::OP_MUL,  1, MinL, M1, 1, MinL, 0},
      '{jvm_alu_pkg::OP_MUL,  0, 64'h1234_5678_9abc_def0, 64'hdead_beef_0000_0003, 0, 0, 0},
      '{jvm_alu_pkg::OP_DIV,  1, 64'd7, 64'd0, 1, 64'd0, 1},
      '{jvm_alu_pkg::OP_REM,  1, 64'd7, 64'd0, 1, 64'd0, 1},
      '{jvm_alu_pkg::OP_DIV,  0, 64'd7, 64'hffff_0000_0000_0000, 1, 64'd0, 1},
      '{jvm_alu_pkg::OP_REM,  0, M1, 64'h1_0000_0000, 1, 64'd0, 1},
      '{jvm_alu_pkg::OP_DIV,  1, MinL, M1, 1, MinL, 0},
      '{jvm_alu_pkg::OP_REM,  1, MinL, M1, 1, 64'd0, 0},
      '{jvm_alu_pkg::OP_DIV,  0, 64'h8000_0000, M1, 1, MinI, 0},
      '{jvm_alu_pkg::OP_REM,  0, 64'h8000_0000, M1, 1, 64'd0, 0},
      '{jvm_alu_pkg::OP_DIV,  1, -64'sd7, 64'd2, 0, 0, 0},
      '{jvm_alu_pkg::OP_REM,  0, -64'sd7, 64'd2, 0, 0, 0},
      '{jvm_alu_pkg::OP_NEG,  1, MinL, M1, 1, MinL, 0},
      '{jvm_alu_pkg::OP_NEG,  0, 64'h8000_0000, 64'd5, 1, MinI, 0},
      '{jvm_alu_pkg::OP_SHL,  0, 64'd1, 64'd63, 1, MinI, 0},
      '{jvm_alu_pkg::OP_SHL,  1, 64'd1, 64'd127, 1, MinL, 0},
      '{jvm_alu_pkg::OP_SHR,  1, MinL, 64'd63, 1, M1, 0},
      '{jvm_alu_pkg::OP_USHR, 0, M1, 64'd31, 1, 64'd1, 0},
      '{jvm_alu_pkg::OP_USHR, 1, M1, 64'd0, 1, M1, 0},
      '{jvm_alu_pkg::OP_AND,  1, M1, MaxL, 1, MaxL, 0},
      '{jvm_alu_pkg::OP_OR,   0, 64'd0, MinL, 1, 64'd0, 0},
      '{jvm_alu_pkg::OP_XOR,  1, M1, MinL, 1, MaxL, 0},
      '{4'd12,                1, M1, M1, 1, 64'd0, 0},
      '{4'd15,                0, M1, M1, 1, 64'd0, 0}
   };

   initial begin
      op_row_type row;
      int         drained;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = 6;
      recv_idle = 72;
      foreach (directed[i]) send_op(directed[i]);
      for (int n = 0; n < RandomOps; n++) begin
         if (n == RandomOps / 3) begin
            send_idle = 72;
            recv_idle = 6;
         end
         if (n == 2 * RandomOps / 3) begin
            // Let the pipeline drain completely before the unthrottled phase.
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_results.size() != 0);
            send_idle = 0;
            recv_idle = 0;
         end
         row.kind  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11));
         row.wide  = 1'($urandom_range(0, 1));
         row.a     = rand64();
         row.b     = ($urandom_range(0, 15) == 0) ? 64'd0 : rand64();
         if ((row.kind == jvm_alu_pkg::OP_DIV || row.kind == jvm_alu_pkg::OP_REM)
             && $urandom_range(0, 9) == 0)
            row.b = M1;
         row.known = 1'b0;
         row.res   = '0;
         row.st    = 1'b0;
         send_op(row);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      drained = 0;
      while (drained < 2 * Latency) begin
         @(negedge clock);
         drained++;
      end
      $display("Sent %0d operations (directed corner cases and random int/long mixes),",
               sent);
      $display("checked %0d responses under sender and receiver back-pressure.", checked);
      if (failures == 0) begin
         $display("jvm_integer_alu_unit regression: pass");
      end else begin
         $display("jvm_integer_alu_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/jvm_alu_pkg.sv
design/jvm_integer_alu_unit.sv
sim/testbench.sv
